// File: src/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer.
// Used by wsd_front, wsd_queue, wsd_back and the top level; no dependencies.
package wsd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_CLOSE   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   localparam logic [15:0] NO_CLOSE_CODE = 16'h1005;

   // 7-bit length codes that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Header byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   // One event from the parser: the back stage applies the key and formats it.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  key;
      logic        frame_end;
      logic [15:0] code;
      logic [3:0]  op;
   } event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/wsd_front.sv
// Front stage: accepts stream bytes, parses frame headers and classifies each byte.
// Pushes one event per result into the queue. Depends on wsd_pkg.
module wsd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  wsd_pkg::queue_status_type q_status,
   output logic                      push,
   output wsd_pkg::event_type        push_item
);

   typedef enum logic [6:0] {
      PH_OPCODE  = 7'b0000001,
      PH_LENGTH  = 7'b0000010,
      PH_EXTLEN  = 7'b0000100,
      PH_MASKKEY = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CLOSE   = 7'b0100000,
      PH_HALTED  = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        enable_ff, enable_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [6:0]  short_len_ff, short_len_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_index_ff, mask_index_in;
   logic [7:0]  close_hi_ff, close_hi_in;
   logic        close_seen_ff, close_seen_in;

   logic        accept;
   logic        hdr_done;
   logic [63:0] hdr_len;
   logic [63:0] ext_len;
   logic [3:0]  count_next;
   logic [3:0]  ext_bytes;
   logic [7:0]  key_sel;
   logic        last;

   assign req_ready  = !q_status.full;
   assign accept     = req_valid && req_ready;
   assign key_sel    = mask_key_ff[{~mask_index_ff, 3'b000} +: 8];
   assign ext_len    = {payload_left_ff[55:0], req_in_byte};
   assign count_next = hdr_count_ff + 4'd1;
   assign ext_bytes  = (short_len_ff == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                            : wsd_pkg::EXT64_BYTES;
   assign last       = (payload_left_ff <= 64'd1);

   always_comb begin
      enable_in       = csr_wr_en ? csr_wr_data : enable_ff;
      phase_in        = phase_ff;
      hdr_count_in    = hdr_count_ff;
      opcode_in       = opcode_ff;
      masked_in       = masked_ff;
      short_len_in    = short_len_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      mask_index_in   = mask_index_ff;
      close_hi_in     = close_hi_ff;
      close_seen_in   = close_seen_ff;
      push            = 1'b0;
      push_item       = '0;
      hdr_done        = 1'b0;
      hdr_len         = payload_left_ff;

      if (accept && phase_ff != PH_HALTED) begin
         if (!enable_ff) begin
            // pass the byte through untouched, parser state holds
            push           = 1'b1;
            push_item.kind = wsd_pkg::KIND_PAYLOAD;
            push_item.data = req_in_byte;
         end else begin
            case (phase_ff)
               PH_OPCODE: begin
                  opcode_in = req_in_byte[3:0];
                  phase_in  = PH_LENGTH;
               end
               PH_LENGTH: begin
                  masked_in    = req_in_byte[7];
                  short_len_in = req_in_byte[6:0];
                  hdr_count_in = '0;
                  if (req_in_byte[6:0] inside {wsd_pkg::LEN_EXT16, wsd_pkg::LEN_EXT64}) begin
                     payload_left_in = '0;
                     phase_in        = PH_EXTLEN;
                  end else begin
                     payload_left_in = {57'd0, req_in_byte[6:0]};
                     mask_key_in     = '0;
                     if (req_in_byte[7]) begin
                        phase_in = PH_MASKKEY;
                     end else begin
                        hdr_done = 1'b1;
                        hdr_len  = {57'd0, req_in_byte[6:0]};
                     end
                  end
               end
               PH_EXTLEN: begin
                  payload_left_in = ext_len;
                  hdr_count_in    = count_next;
                  if (count_next == ext_bytes) begin
                     mask_key_in  = '0;
                     hdr_count_in = '0;
                     if (masked_ff) begin
                        phase_in = PH_MASKKEY;
                     end else begin
                        hdr_done = 1'b1;
                        hdr_len  = ext_len;
                     end
                  end
               end
               PH_MASKKEY: begin
                  mask_key_in  = {mask_key_ff[23:0], req_in_byte};
                  hdr_count_in = count_next;
                  if (count_next == wsd_pkg::KEY_BYTES) begin
                     hdr_done = 1'b1;
                  end
               end
               PH_PAYLOAD: begin
                  mask_index_in       = mask_index_ff + 2'd1;
                  payload_left_in     = last ? 64'd0 : payload_left_ff - 64'd1;
                  push                = 1'b1;
                  push_item.kind      = wsd_pkg::KIND_PAYLOAD;
                  push_item.data      = req_in_byte;
                  push_item.key       = key_sel;
                  push_item.frame_end = last;
                  if (last) begin
                     phase_in = PH_OPCODE;
                  end
               end
               PH_CLOSE: begin
                  mask_index_in = mask_index_ff + 2'd1;
                  close_seen_in = 1'b1;
                  if (!close_seen_ff) begin
                     close_hi_in = req_in_byte ^ key_sel;
                  end else begin
                     // second code byte: the back stage unmasks the low byte
                     phase_in       = PH_HALTED;
                     push           = 1'b1;
                     push_item.kind = wsd_pkg::KIND_CLOSE;
                     push_item.code = {close_hi_ff, req_in_byte};
                     push_item.key  = key_sel;
                  end
               end
               default: begin
                  phase_in = PH_HALTED;
               end
            endcase
         end
      end

      if (hdr_done) begin
         mask_index_in = '0;
         if (opcode_ff == wsd_pkg::OP_CLOSE) begin
            if (hdr_len < 64'd2) begin
               phase_in       = PH_HALTED;
               push           = 1'b1;
               push_item.kind = wsd_pkg::KIND_CLOSE;
               push_item.code = wsd_pkg::NO_CLOSE_CODE;
            end else begin
               close_seen_in = 1'b0;
               phase_in      = PH_CLOSE;
            end
         end else if (!(opcode_ff inside {wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY})
                      && hdr_len != 64'd0) begin
            phase_in       = PH_HALTED;
            push           = 1'b1;
            push_item.kind = wsd_pkg::KIND_ERROR;
            push_item.op   = opcode_ff;
         end else begin
            phase_in = (hdr_len == 64'd0) ? PH_OPCODE : PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         phase_ff        <= PH_OPCODE;
         hdr_count_ff    <= '0;
         opcode_ff       <= '0;
         masked_ff       <= 1'b0;
         short_len_ff    <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         mask_index_ff   <= '0;
         close_hi_ff     <= '0;
         close_seen_ff   <= 1'b0;
      end else begin
         enable_ff       <= enable_in;
         phase_ff        <= phase_in;
         hdr_count_ff    <= hdr_count_in;
         opcode_ff       <= opcode_in;
         masked_ff       <= masked_in;
         short_len_ff    <= short_len_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         mask_index_ff   <= mask_index_in;
         close_hi_ff     <= close_hi_in;
         close_seen_ff   <= close_seen_in;
      end
   end

endmodule

// File: src/wsd_queue.sv
// Short event queue between the parser front and the output back stage.
// Register-based FIFO of DEPTH entries. Depends on wsd_pkg.
module wsd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  wsd_pkg::event_type        push_item,
   input  logic                      pop,
   output wsd_pkg::event_type        pop_item,
   output wsd_pkg::queue_status_type status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsd_pkg::event_type entries_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/wsd_back.sv
// Back stage: pops events, unmasks data and close codes, and holds the result register.
// Drives the rsp_ channel. Depends on wsd_pkg.
module wsd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  wsd_pkg::queue_status_type q_status,
   input  wsd_pkg::event_type        q_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_data_byte,
   output logic                      rsp_frame_end,
   output logic [15:0]               rsp_close_code,
   output logic [3:0]                rsp_bad_opcode
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  data_ff;
   logic        end_ff;
   logic [15:0] code_ff;
   logic [3:0]  op_ff;
   logic        is_payload, is_close, is_error;

   // load whenever the register is free or being emptied this cycle
   assign pop        = !q_status.empty && (!valid_ff || rsp_ready);
   assign valid_in   = pop || (valid_ff && !rsp_ready);
   assign is_payload = (q_item.kind == wsd_pkg::KIND_PAYLOAD);
   assign is_close   = (q_item.kind == wsd_pkg::KIND_CLOSE);
   assign is_error   = (q_item.kind == wsd_pkg::KIND_ERROR);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= q_item.kind;
         data_ff <= is_payload ? (q_item.data ^ q_item.key) : 8'd0;
         end_ff  <= is_payload && q_item.frame_end;
         code_ff <= is_close ? (q_item.code ^ {8'd0, q_item.key}) : 16'd0;
         op_ff   <= is_error ? q_item.op : 4'd0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_frame_end  = end_ff;
   assign rsp_close_code = code_ff;
   assign rsp_bad_opcode = op_ff;

endmodule

// File: src/websocket_frame_deframer_unit.sv
// WebSocket receive deframer: takes one stream byte per cycle on req_ and gives at most
// one result per byte on rsp_. With csr enable low, bytes pass through as payload; with
// it high, frame headers are parsed and payload bytes come out unmasked, frame_end on the
// last one. A close frame yields one close event (0x1005 with no code), a data-bearing
// frame with an opcode other than text or binary yields one error event, and after either
// the block swallows every byte until reset. A byte is accepted every cycle while the
// event queue has room; each result is written to the event queue and then to the output
// register, and the QUEUE_DEPTH-entry queue plus the output register absorb stalls
// on the rsp_ side. Write the enable only while the block is idle.
module websocket_frame_deframer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic [15:0] rsp_close_code,
   output logic [3:0]  rsp_bad_opcode,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   wsd_pkg::queue_status_type q_status;
   wsd_pkg::event_type        push_item;
   wsd_pkg::event_type        pop_item;
   logic                      push;
   logic                      pop;

   wsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   wsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_item         (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_close_code (rsp_close_code),
      .rsp_bad_opcode (rsp_bad_opcode)
   );

   // a close or error event is the last result before reset
   a_event_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind != wsd_pkg::KIND_PAYLOAD |=> !rsp_valid)
      else $error("result delivered after close or error event");

   // the output register only fills from a non-empty queue
   a_load_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_status.empty))
      else $error("output loaded while queue was empty");

   // the queue never takes an event while full unless an event is popped at the same time
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full || pop)
      else $error("event pushed into full queue");

endmodule
